### rtl/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants for the min-max contrast stretch block.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  localparam int unsigned PixW    = 16;
  localparam int unsigned OutW    = 8;
  localparam int unsigned RemW    = PixW + OutW;
  localparam int unsigned NumCells = OutW;

  localparam logic [PixW-1:0] PixMax = 16'hFFFF;
  localparam logic [PixW-1:0] PixMin = 16'h0000;
  localparam logic [OutW-1:0] OutMax = 8'hFF;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [OutW-1:0] out_t;
  typedef logic [RemW-1:0] rem_t;

  // one item travelling along the divider chain
  typedef struct packed {
    logic  valid;
    logic  forced;
    rem_t  rem;
    pix_t  span;
    out_t  quo;
  } cell_t;

endpackage

### rtl/mmcs_cell.sv
// ----------------------------------------------------------------------------
// mmcs_cell
// One restoring-division step: decides one quotient bit and passes the item on.
// ----------------------------------------------------------------------------
module mmcs_cell #(
  parameter int unsigned BitPos = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  mmcs_pkg::cell_t cell_i,
  output mmcs_pkg::cell_t cell_o
);
  import mmcs_pkg::*;

  rem_t  shifted;
  logic  take;
  cell_t cell_d;
  cell_t cell_q;

  assign shifted = rem_t'(cell_i.span) << BitPos;
  assign take    = !cell_i.forced && (cell_i.rem >= shifted);

  always_comb begin
    cell_d = cell_i;
    if (take) begin
      cell_d.rem         = cell_i.rem - shifted;
      cell_d.quo[BitPos] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/minmax_contrast_stretch.sv
// ----------------------------------------------------------------------------
// minmax_contrast_stretch
// Two-pass min-max stretch of 16-bit pixels to 8 bits through a divider chain.
// ----------------------------------------------------------------------------
// structure: a convert item passes through the setup register (loaded at acceptance),
//   8 division cells of one quotient bit each, and
//   1 output register
// throughput: one item per cycle while the chain advances; measure items complete at acceptance
// the chain stalls only while a finished result waits at the output
// reset: min 65535, max 0, chain and output empty
module minmax_contrast_stretch (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic                  frame_start_i,
  input  logic [15:0]           pixel_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            scaled_pixel_o
);
  import mmcs_pkg::*;

  pix_t  lo_q, lo_d, hi_q, hi_d;
  pix_t  lo_base, hi_base, diff;
  logic  in_acc, adv, out_load;
  logic  flat, below, above;
  cell_t setup_d, setup_q;
  cell_t chain [NumCells+1];
  logic  out_valid_q;
  out_t  out_data_q;

  assign adv        = !chain[NumCells].valid || !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = !out_valid_q || out_ready_i;

  // measure pass
  always_comb begin
    lo_base = frame_start_i ? PixMax : lo_q;
    hi_base = frame_start_i ? PixMin : hi_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    if (in_acc && !req_type_i) begin
      lo_d = (pixel_value_i < lo_base) ? pixel_value_i : lo_base;
      hi_d = (pixel_value_i > hi_base) ? pixel_value_i : hi_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= PixMax;
      hi_q <= PixMin;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // convert pass setup
  always_comb begin
    flat  = hi_q <= lo_q;
    below = pixel_value_i <= lo_q;
    above = pixel_value_i >= hi_q;
    diff  = pixel_value_i - lo_q;
    setup_d.valid  = in_acc && req_type_i;
    setup_d.forced = flat || below || above;
    setup_d.span   = hi_q - lo_q;
    setup_d.rem    = (rem_t'(diff) << OutW) - rem_t'(diff);
    setup_d.quo    = (!flat && !below && above) ? OutMax : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= '0;
    end else if (adv) begin
      setup_q <= setup_d;
    end
  end

  assign chain[0] = setup_q;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    mmcs_cell #(
      .BitPos(NumCells - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .cell_i(chain[k]),
      .cell_o(chain[k+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= chain[NumCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= chain[NumCells].quo;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scaled_pixel_o = out_data_q;

endmodule

### rtl/mmcs_checker.sv
// ----------------------------------------------------------------------------
// mmcs_checker
// Port-level checks for the min-max contrast stretch block.
// ----------------------------------------------------------------------------
module mmcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  scaled_pixel_o
);

  // input side waits only behind an item held at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // a new result appears only after the chain moved
  a_rise_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared while chain was stalled");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(scaled_pixel_o)))
    else $error("result dropped or changed before acceptance");

endmodule

bind minmax_contrast_stretch mmcs_checker u_mmcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .scaled_pixel_o(scaled_pixel_o)
);
